/* rtl/rap_pkg.sv */
// Package for the array-of-bulk-strings request parser: character codes,
// result kinds, parser phases, register indexes and default widths.
// No dependencies.
package rap_pkg;

  localparam int DEF_ARG_BITS = 10;
  localparam int DEF_LEN_BITS = 24;

  localparam longint unsigned DEF_MAX_ARGS     = 1023;
  localparam longint unsigned DEF_MAX_BULK_LEN = 524288;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ARGS     = 1'b0,
    CFG_MAX_BULK_LEN = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY_ARG = 2'd1,
    KIND_ERROR     = 2'd2
  } kind_t;

  typedef enum logic [7:0] {
    PH_HUNT     = 8'b0000_0001,
    PH_COUNT    = 8'b0000_0010,
    PH_COUNT_LF = 8'b0000_0100,
    PH_DOLLAR   = 8'b0000_1000,
    PH_LEN      = 8'b0001_0000,
    PH_LEN_LF   = 8'b0010_0000,
    PH_PAYLOAD  = 8'b0100_0000,
    PH_TRAILER  = 8'b1000_0000
  } phase_t;

endpackage

/* rtl/rap_cfg.sv */
// Configuration register file of the request parser: argument count and
// argument length limits. Depends on rap_pkg.
module rap_cfg
  import rap_pkg::*;
#(
  parameter int ARG_BITS = DEF_ARG_BITS,
  parameter int LEN_BITS = DEF_LEN_BITS,
  localparam int CFG_W = (LEN_BITS > ARG_BITS) ? LEN_BITS : ARG_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [ARG_BITS-1:0]  max_args,
  output logic [LEN_BITS-1:0]  max_bulk_len
);

  localparam logic [63:0] ARG_ALL = (64'd1 << ARG_BITS) - 64'd1;
  localparam logic [63:0] LEN_ALL = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [63:0] RST_ARGS =
    (64'(DEF_MAX_ARGS) > ARG_ALL) ? ARG_ALL : 64'(DEF_MAX_ARGS);
  localparam logic [63:0] RST_LEN =
    (64'(DEF_MAX_BULK_LEN) > LEN_ALL) ? LEN_ALL : 64'(DEF_MAX_BULK_LEN);

  logic [ARG_BITS-1:0] max_args_r;
  logic [LEN_BITS-1:0] max_bulk_len_r;

  assign cfg_ready    = 1'b1;
  assign max_args     = max_args_r;
  assign max_bulk_len = max_bulk_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r     <= RST_ARGS[ARG_BITS-1:0];
      max_bulk_len_r <= RST_LEN[LEN_BITS-1:0];
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_ARGS:     max_args_r     <= cfg_data[ARG_BITS-1:0];
        CFG_MAX_BULK_LEN: max_bulk_len_r <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/rap_core.sv */
// Parser core: input byte register, phase machine with number and argument
// counters, and the result register. Depends on rap_pkg.
module rap_core
  import rap_pkg::*;
#(
  parameter int ARG_BITS = DEF_ARG_BITS,
  parameter int LEN_BITS = DEF_LEN_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ARG_BITS-1:0] max_args,
  input  logic [LEN_BITS-1:0] max_bulk_len,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_data,
  output logic [ARG_BITS-1:0] out_arg_index,
  output logic                out_last_arg,
  output logic                out_last_cmd
);

  localparam int ACC_W = (LEN_BITS > ARG_BITS) ? LEN_BITS : ARG_BITS;
  localparam int V_W   = ACC_W + 4;

  // input register
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       advance;

  // parser state
  phase_t              phase_r, phase_nxt;
  logic [ACC_W-1:0]    accum_r, accum_nxt;
  logic                digit_seen_r, digit_seen_nxt;
  logic [ARG_BITS-1:0] args_left_r, args_left_nxt;
  logic [ARG_BITS-1:0] arg_number_r, arg_number_nxt;
  logic [LEN_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]          trailer_left_r, trailer_left_nxt;

  // result register
  logic                out_valid_r;
  kind_t               kind_r, kind_nxt;
  logic [7:0]          data_r, data_nxt;
  logic [ARG_BITS-1:0] idx_r, idx_nxt;
  logic                last_arg_r, last_arg_nxt;
  logic                last_cmd_r, last_cmd_nxt;
  logic                emit;

  logic             is_digit;
  logic [V_W-1:0]   num_v;
  logic [V_W-1:0]   limit;
  logic             over;
  logic [1:0]       trailer_dec;
  logic [ARG_BITS-1:0] args_dec;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign is_digit = byte_r inside {[CH_ZERO:CH_NINE]};
  assign num_v    = V_W'({accum_r, 3'b000}) + V_W'({accum_r, 1'b0})
                  + V_W'(byte_r - CH_ZERO);
  assign limit    = (phase_r == PH_COUNT) ? V_W'(max_args) : V_W'(max_bulk_len);
  assign over     = num_v > limit;
  assign trailer_dec = trailer_left_r - 2'd1;
  assign args_dec    = args_left_r - ARG_BITS'(1);

  always_comb begin
    logic fail;
    fail             = 1'b0;
    emit             = 1'b0;
    phase_nxt        = phase_r;
    accum_nxt        = accum_r;
    digit_seen_nxt   = digit_seen_r;
    args_left_nxt    = args_left_r;
    arg_number_nxt   = arg_number_r;
    bytes_left_nxt   = bytes_left_r;
    trailer_left_nxt = trailer_left_r;
    kind_nxt         = KIND_PAYLOAD;
    data_nxt         = 8'h00;
    idx_nxt          = arg_number_r;
    last_arg_nxt     = 1'b0;
    last_cmd_nxt     = 1'b0;

    case (phase_r)
      PH_HUNT: begin
        if (byte_r == CH_STAR) begin
          phase_nxt      = PH_COUNT;
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          arg_number_nxt = '0;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (is_digit) begin
          if (over) begin
            fail = 1'b1;
          end else begin
            accum_nxt      = num_v[ACC_W-1:0];
            digit_seen_nxt = 1'b1;
          end
        end else if (byte_r == CH_CR && digit_seen_r) begin
          phase_nxt = (phase_r == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else begin
          fail = 1'b1;
        end
      end
      PH_COUNT_LF: begin
        if (byte_r != CH_LF) begin
          fail = 1'b1;
        end else begin
          args_left_nxt  = accum_r[ARG_BITS-1:0];
          arg_number_nxt = '0;
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          phase_nxt      = (accum_r[ARG_BITS-1:0] == '0) ? PH_HUNT : PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (byte_r != CH_DOLLAR) begin
          fail = 1'b1;
        end else begin
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          phase_nxt      = PH_LEN;
        end
      end
      PH_LEN_LF: begin
        if (byte_r != CH_LF) begin
          fail = 1'b1;
        end else begin
          bytes_left_nxt = accum_r[LEN_BITS-1:0];
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          if (accum_r[LEN_BITS-1:0] == '0) begin
            emit             = 1'b1;
            kind_nxt         = KIND_EMPTY_ARG;
            last_arg_nxt     = 1'b1;
            last_cmd_nxt     = (args_left_r == ARG_BITS'(1));
            trailer_left_nxt = 2'd2;
            phase_nxt        = PH_TRAILER;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit           = 1'b1;
        kind_nxt       = KIND_PAYLOAD;
        data_nxt       = byte_r;
        last_arg_nxt   = (bytes_left_r == LEN_BITS'(1));
        last_cmd_nxt   = (bytes_left_r == LEN_BITS'(1)) && (args_left_r == ARG_BITS'(1));
        bytes_left_nxt = bytes_left_r - LEN_BITS'(1);
        if (bytes_left_r == LEN_BITS'(1)) begin
          trailer_left_nxt = 2'd2;
          phase_nxt        = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        trailer_left_nxt = trailer_dec;
        if (trailer_dec == 2'd0) begin
          args_left_nxt = args_dec;
          if (args_dec == '0) begin
            arg_number_nxt = '0;
            phase_nxt      = PH_HUNT;
          end else begin
            arg_number_nxt = arg_number_r + ARG_BITS'(1);
            phase_nxt      = PH_DOLLAR;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase

    if (fail) begin
      emit             = 1'b1;
      kind_nxt         = KIND_ERROR;
      data_nxt         = 8'h00;
      idx_nxt          = arg_number_r;
      last_arg_nxt     = 1'b0;
      last_cmd_nxt     = 1'b0;
      phase_nxt        = PH_HUNT;
      accum_nxt        = '0;
      digit_seen_nxt   = 1'b0;
      args_left_nxt    = '0;
      arg_number_nxt   = '0;
      bytes_left_nxt   = '0;
      trailer_left_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      phase_r        <= PH_HUNT;
      accum_r        <= '0;
      digit_seen_r   <= 1'b0;
      args_left_r    <= '0;
      arg_number_r   <= '0;
      bytes_left_r   <= '0;
      trailer_left_r <= 2'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        phase_r        <= phase_nxt;
        accum_r        <= accum_nxt;
        digit_seen_r   <= digit_seen_nxt;
        args_left_r    <= args_left_nxt;
        arg_number_r   <= arg_number_nxt;
        bytes_left_r   <= bytes_left_nxt;
        trailer_left_r <= trailer_left_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
    if (advance && emit) begin
      kind_r     <= kind_nxt;
      data_r     <= data_nxt;
      idx_r      <= idx_nxt;
      last_arg_r <= last_arg_nxt;
      last_cmd_r <= last_cmd_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_data      = data_r;
  assign out_arg_index = idx_r;
  assign out_last_arg  = last_arg_r;
  assign out_last_cmd  = last_cmd_r;

endmodule

/* rtl/resp_array_command_parser.sv */
// Top level of the array-of-bulk-strings request parser.
// Depends on rap_pkg, rap_cfg and rap_core.
//
//   channel | ports            | moves
//   --------+------------------+-------------------------------------------
//   input   | in_t*            | one request byte per transaction
//   result  | out_t*           | payload byte, empty argument or error
//   config  | cfg_*            | limit register write
//
// One byte per clock sustained while the result is not stalled; a byte accepted
// into the input register is processed by the phase machine and lands in the result register.
// Reset (rst_n low, synchronous) empties both registers, returns to star
// hunting and loads the default limits.
// A stalled result holds the phase machine; the input register still takes a
// byte only while it is empty, and in_tready drops once it is full.
module resp_array_command_parser
  import rap_pkg::*;
#(
  parameter int ARG_BITS = DEF_ARG_BITS,
  parameter int LEN_BITS = DEF_LEN_BITS,
  localparam int CFG_W  = (LEN_BITS > ARG_BITS) ? LEN_BITS : ARG_BITS,
  localparam int DATA_W = ((8 + ARG_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [7:0] byte_in
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,   // data_out, arg_index, zero pad
  output logic [2:0]           out_tuser,   // kind [1:0], last_of_arg [2]
  output logic                 out_tlast,   // last_of_command
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [ARG_BITS-1:0] max_args;
  logic [LEN_BITS-1:0] max_bulk_len;
  logic [1:0]          kind;
  logic [7:0]          data_out;
  logic [ARG_BITS-1:0] arg_index;
  logic                last_arg;

  rap_cfg #(
    .ARG_BITS (ARG_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .max_args     (max_args),
    .max_bulk_len (max_bulk_len)
  );

  rap_core #(
    .ARG_BITS (ARG_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .max_args      (max_args),
    .max_bulk_len  (max_bulk_len),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_byte       (in_tdata),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_kind      (kind),
    .out_data      (data_out),
    .out_arg_index (arg_index),
    .out_last_arg  (last_arg),
    .out_last_cmd  (out_tlast)
  );

  assign out_tdata = DATA_W'({arg_index, data_out});
  assign out_tuser = {last_arg, kind};

endmodule

/* tb/resp_array_command_parser_tb.sv */
// Self-checking testbench for resp_array_command_parser: directed request bytes,
// then random well-formed and malformed requests under several limit settings.
// Depends on rap_pkg and the parser RTL; results are predicted byte by byte.
module resp_array_command_parser_tb;
  import rap_pkg::*;

  localparam int ARG_W  = DEF_ARG_BITS;
  localparam int LEN_W  = DEF_LEN_BITS;
  localparam int DATA_W = ((8 + ARG_W + 7) / 8) * 8;
  localparam int CFG_W  = (LEN_W > ARG_W) ? LEN_W : ARG_W;
  localparam int QUIET_LIMIT = 2000;
  localparam int DIR_N = 29;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [ARG_W-1:0] idx;
    logic             last_arg;
    logic             last_cmd;
  } parse_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    parse_res_t res;
  } dir_row_t;

  typedef enum logic [1:0] {
    NUM_TAKEN,
    NUM_BAD,
    NUM_DONE
  } num_ev_t;

  localparam parse_res_t NO_RES = '0;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{8'h00, 1'b0, NO_RES},
    '{CH_STAR, 1'b0, NO_RES}, '{8'h30, 1'b0, NO_RES},
    '{CH_CR, 1'b0, NO_RES}, '{CH_LF, 1'b0, NO_RES},
    '{CH_STAR, 1'b0, NO_RES}, '{8'h31, 1'b0, NO_RES},
    '{CH_CR, 1'b0, NO_RES}, '{CH_LF, 1'b0, NO_RES},
    '{CH_DOLLAR, 1'b0, NO_RES}, '{8'h30, 1'b0, NO_RES}, '{CH_CR, 1'b0, NO_RES},
    '{CH_LF, 1'b1, '{KIND_EMPTY_ARG, 8'h00, 10'd0, 1'b1, 1'b1}},
    '{CH_STAR, 1'b0, NO_RES}, '{CH_STAR, 1'b0, NO_RES},
    '{CH_STAR, 1'b0, NO_RES},
    '{CH_MINUS, 1'b1, '{KIND_ERROR, 8'h00, 10'd0, 1'b0, 1'b0}},
    '{CH_STAR, 1'b0, NO_RES}, '{8'h32, 1'b0, NO_RES},
    '{CH_CR, 1'b0, NO_RES}, '{CH_LF, 1'b0, NO_RES},
    '{CH_DOLLAR, 1'b0, NO_RES}, '{8'h31, 1'b0, NO_RES},
    '{CH_CR, 1'b0, NO_RES}, '{CH_LF, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 10'd0, 1'b1, 1'b0}},
    '{CH_CR, 1'b0, NO_RES}, '{CH_LF, 1'b0, NO_RES},
    '{CH_HASH, 1'b1, '{KIND_ERROR, 8'h00, 10'd1, 1'b0, 1'b0}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;
  logic [2:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  logic [ARG_W-1:0] lim_args;
  logic [LEN_W-1:0] lim_len;
  phase_t           ps_phase;
  logic [LEN_W-1:0] ps_num;
  logic             ps_digit;
  logic [ARG_W-1:0] ps_args_left;
  logic [ARG_W-1:0] ps_arg_no;
  logic [LEN_W-1:0] ps_bytes_left;
  logic [1:0]       ps_trailer_left;

  parse_res_t  pending_results[$];
  bit          gaps_on;
  bit          stalls_on;
  logic [3:0]  stall_left = '0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned req_bytes = 0;
  int unsigned n_payload = 0;
  int unsigned n_empty = 0;
  int unsigned n_error = 0;

  resp_array_command_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void queue_result(input parse_res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic num_ev_t take_digit(input logic [7:0] b,
                                         input logic [LEN_W-1:0] limit);
    logic [LEN_W+11:0] v;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      v = (LEN_W+12)'(ps_num) * 10 + (LEN_W+12)'(b[3:0]);
      if (v > (LEN_W+12)'(limit)) return NUM_BAD;
      ps_num = v[LEN_W-1:0];
      ps_digit = 1'b1;
      return NUM_TAKEN;
    end
    if (b == CH_CR) return ps_digit ? NUM_DONE : NUM_BAD;
    return NUM_BAD;
  endfunction

  function automatic parse_res_t abort_request();
    parse_res_t r;
    r = NO_RES;
    r.kind = KIND_ERROR;
    r.idx = ps_arg_no;
    ps_phase = PH_HUNT;
    ps_num = '0;
    ps_digit = 1'b0;
    ps_args_left = '0;
    ps_arg_no = '0;
    ps_bytes_left = '0;
    ps_trailer_left = '0;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output parse_res_t r);
    num_ev_t ev;
    logic    last;
    r = NO_RES;
    case (ps_phase)
      PH_HUNT: begin
        if (b == CH_STAR) begin
          ps_phase = PH_COUNT;
          ps_num = '0;
          ps_digit = 1'b0;
          ps_arg_no = '0;
        end
        return 1'b0;
      end
      PH_COUNT: begin
        ev = take_digit(b, LEN_W'(lim_args));
        if (ev == NUM_BAD) begin
          r = abort_request();
          return 1'b1;
        end
        if (ev == NUM_DONE) ps_phase = PH_COUNT_LF;
        return 1'b0;
      end
      PH_COUNT_LF: begin
        if (b != CH_LF) begin
          r = abort_request();
          return 1'b1;
        end
        ps_args_left = ps_num[ARG_W-1:0];
        ps_arg_no = '0;
        ps_num = '0;
        ps_digit = 1'b0;
        ps_phase = (ps_args_left == '0) ? PH_HUNT : PH_DOLLAR;
        return 1'b0;
      end
      PH_DOLLAR: begin
        if (b != CH_DOLLAR) begin
          r = abort_request();
          return 1'b1;
        end
        ps_num = '0;
        ps_digit = 1'b0;
        ps_phase = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        ev = take_digit(b, lim_len);
        if (ev == NUM_BAD) begin
          r = abort_request();
          return 1'b1;
        end
        if (ev == NUM_DONE) ps_phase = PH_LEN_LF;
        return 1'b0;
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          r = abort_request();
          return 1'b1;
        end
        ps_bytes_left = ps_num;
        ps_num = '0;
        ps_digit = 1'b0;
        if (ps_bytes_left == '0) begin
          r.kind = KIND_EMPTY_ARG;
          r.idx = ps_arg_no;
          r.last_arg = 1'b1;
          r.last_cmd = (ps_args_left == ARG_W'(1));
          ps_trailer_left = 2'd2;
          ps_phase = PH_TRAILER;
          return 1'b1;
        end
        ps_phase = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        last = (ps_bytes_left == LEN_W'(1));
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.idx = ps_arg_no;
        r.last_arg = last;
        r.last_cmd = last && (ps_args_left == ARG_W'(1));
        ps_bytes_left = ps_bytes_left - 1'b1;
        if (last) begin
          ps_trailer_left = 2'd2;
          ps_phase = PH_TRAILER;
        end
        return 1'b1;
      end
      default: begin
        ps_trailer_left = ps_trailer_left - 1'b1;
        if (ps_trailer_left == 2'd0) begin
          ps_args_left = ps_args_left - 1'b1;
          ps_arg_no = ps_arg_no + 1'b1;
          if (ps_args_left == '0) begin
            ps_arg_no = '0;
            ps_phase = PH_HUNT;
          end else begin
            ps_phase = PH_DOLLAR;
          end
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input parse_res_t typed_res);
    parse_res_t pr;
    bit         got;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = parse_byte(b, pr);
    bytes_sent++;
    if (typed) queue_result(typed_res);
    else if (got) queue_result(pr);
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], 1'b0, NO_RES);
  endtask

  function automatic void append_dec(ref logic [7:0] q[$], input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) put_byte(q, CH_ZERO);
    for (int i = 0; i < s.len(); i++) put_byte(q, 8'(s[i]));
  endfunction

  task automatic await_quiet();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [ARG_W-1:0] a, input logic [LEN_W-1:0] l);
    await_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_ARGS;
    cfg_data  <= CFG_W'(a);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAX_BULK_LEN;
    cfg_data  <= CFG_W'(l);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lim_args = a;
    lim_len  = l;
  endtask

  task automatic send_request(input int unsigned n_args, input int unsigned len_cap,
                              input bit corrupt);
    logic [7:0]  q[$];
    int unsigned len;
    put_byte(q, CH_STAR);
    append_dec(q, n_args);
    put_byte(q, CH_CR);
    put_byte(q, CH_LF);
    for (int i = 0; i < n_args; i++) begin
      put_byte(q, CH_DOLLAR);
      len = ($urandom_range(0, 7) == 0) ? len_cap : $urandom_range(0, len_cap);
      append_dec(q, len);
      put_byte(q, CH_CR);
      put_byte(q, CH_LF);
      repeat (len) put_byte(q, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
        put_byte(q, CH_CR);
        put_byte(q, CH_LF);
      end else begin
        put_byte(q, 8'($urandom_range(0, 255)));
        put_byte(q, 8'($urandom_range(0, 255)));
      end
    end
    if (corrupt) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    req_bytes += q.size();
    send_bytes(q);
  endtask

  task automatic send_malformed();
    logic [7:0] q[$];
    put_byte(q, CH_STAR);
    case ($urandom_range(0, 6))
      0: append_dec(q, longint'(lim_args) + 1);
      1: put_byte(q, CH_CR);
      2: begin
        put_byte(q, 8'h33);
        put_byte(q, CH_CR);
        put_byte(q, CH_MINUS);
      end
      3: put_byte(q, CH_MINUS);
      default: begin
        put_byte(q, 8'h31);
        put_byte(q, CH_CR);
        put_byte(q, CH_LF);
        put_byte(q, CH_DOLLAR);
        case ($urandom_range(0, 2))
          0: append_dec(q, longint'(lim_len) + 1);
          1: put_byte(q, CH_CR);
          default: begin
            put_byte(q, 8'h32);
            put_byte(q, CH_HASH);
          end
        endcase
      end
    endcase
    put_byte(q, CH_CR);
    put_byte(q, CH_LF);
    send_bytes(q);
  endtask

  task automatic run_random(input int unsigned quota, input bit idle);
    logic [7:0]  q[$];
    int unsigned start;
    int unsigned sel;
    int unsigned n;
    int unsigned cap;
    start = req_bytes;
    stalls_on = idle;
    while (req_bytes - start < quota) begin
      gaps_on = idle && ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (idle && sel < 3) await_quiet();
      if (sel < 72) begin
        n = ($urandom_range(0, 19) == 0) ? 0
          : $urandom_range(1, (lim_args < 4) ? lim_args : 4);
        cap = (lim_len <= 64) ? lim_len : 12;
        send_request(n, cap, sel >= 64);
      end else if (sel < 82) begin
        q.delete();
        repeat ($urandom_range(1, 6)) put_byte(q, 8'($urandom_range(0, 255)));
        send_bytes(q);
      end else begin
        send_malformed();
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1'b1;
      out_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= 4'($urandom_range(0, 8));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    parse_res_t got;
    parse_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind     = kind_t'(out_tuser[1:0]);
      got.data     = out_tdata[7:0];
      got.idx      = out_tdata[8 +: ARG_W];
      got.last_arg = out_tuser[2];
      got.last_cmd = out_tlast;
      case (got.kind)
        KIND_PAYLOAD:   n_payload++;
        KIND_EMPTY_ARG: n_empty++;
        default:        n_error++;
      endcase
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d data=%02h idx=%0d ", got.kind, got.data,
                   got.idx, "last_arg=%0b last_cmd=%0b", got.last_arg, got.last_cmd);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.idx !== want.idx ||
            got.last_arg !== want.last_arg || got.last_cmd !== want.last_cmd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind=%0d data=%02h idx=%0d la=%0b lc=%0b, ",
                     want.kind, want.data, want.idx, want.last_arg, want.last_cmd,
                     "got kind=%0d data=%02h idx=%0d la=%0b lc=%0b",
                     got.kind, got.data, got.idx, got.last_arg, got.last_cmd);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("FAIL resp_array_command_parser");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_ARGS;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    lim_args  = ARG_W'(DEF_MAX_ARGS);
    lim_len   = LEN_W'(DEF_MAX_BULK_LEN);
    ps_phase  = PH_HUNT;
    ps_num    = '0;
    ps_digit  = 1'b0;
    ps_args_left    = '0;
    ps_arg_no       = '0;
    ps_bytes_left   = '0;
    ps_trailer_left = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    run_random(250, 1'b1);
    set_limits(ARG_W'(1), LEN_W'(0));
    run_random(150, 1'b1);
    set_limits(ARG_W'(1023), LEN_W'(24'hFFFFFF));
    run_random(250, 1'b1);
    set_limits(ARG_W'($urandom_range(2, 8)), LEN_W'($urandom_range(1, 16)));
    send_request(lim_args, 1, 1'b0);
    run_random(200, 1'b1);
    set_limits(ARG_W'($urandom_range(1, 1023)), LEN_W'($urandom_range(0, 40)));
    gaps_on = 1'b0;
    run_random(150, 1'b0);
    await_quiet();

    $display("sent %0d request bytes over five limit settings; ", bytes_sent,
             "checked %0d payload, %0d empty-argument and %0d error results",
             n_payload, n_empty, n_error);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("PASS resp_array_command_parser");
    end else begin
      $display("FAIL resp_array_command_parser");
    end
    $finish;
  end

endmodule
